FILE: hdl/netstr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_pkg
// shared types and character codes for the netstring deframer
// ---------------------------------------------------------------------------
package netstr_pkg;

    localparam int FRAME_W = 25;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_DATA  = 2'd1,
        PH_COMMA = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_BADCHAR  = 2'd0,
        ERR_EMPTY    = 2'd1,
        ERR_COMMA    = 2'd2,
        ERR_OVERFLOW = 2'd3
    } err_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           payload_byte;
        logic [FRAME_W-1:0]   frame_bytes;
        err_t                 error_code;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/netstr_byte_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_byte_if
// valid/ready channel carrying one raw stream byte per word
// ---------------------------------------------------------------------------
interface netstr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

FILE: hdl/netstr_result_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_result_if
// valid/ready channel carrying one deframer result per word
// ---------------------------------------------------------------------------
interface netstr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [24:0] frame_bytes;
    logic [1:0]  error_code;

    modport source (output valid, output kind, output payload_byte,
                    output frame_bytes, output error_code, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input frame_bytes, input error_code, output ready);
endinterface
`default_nettype wire

FILE: hdl/netstr_in_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_in_stage
// input register holding one accepted byte until the parser takes it
// ---------------------------------------------------------------------------
module netstr_in_stage
    import netstr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    netstr_byte_if.sink  byte_chan,
    input  wire logic    advance,
    output logic         s1_valid,
    output logic [7:0]   s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign byte_chan.ready = !valid_reg || advance;
    assign take            = byte_chan.valid && byte_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_chan.byte_in;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule
`default_nettype wire

FILE: hdl/netstr_parse.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_parse
// parse state and one-byte next-state / result logic
// ---------------------------------------------------------------------------
module netstr_parse
    import netstr_pkg::*;
#(
    parameter int LEN_BITS   = 24,
    parameter int MAX_DIGITS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] cur_byte,
    output logic            res_valid,
    output result_t         res
);

    localparam int         SUM_W     = ((LEN_BITS > FRAME_W) ? LEN_BITS : FRAME_W) + 1;
    localparam logic [3:0] MAX_DIG_C = 4'(MAX_DIGITS);

    phase_t              phase_reg, phase_next;
    logic [3:0]          digits_reg, digits_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;

    logic [LEN_BITS+3:0] len_x10;
    logic [LEN_BITS-1:0] rem_dec;
    logic [SUM_W-1:0]    total;
    logic                num_char;

    // length * 10 + digit, with four guard bits for the overflow test
    assign len_x10  = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1)
                    + (LEN_BITS + 4)'(cur_byte - CH_0);
    assign rem_dec  = rem_reg - 1'b1;
    assign total    = SUM_W'(digits_reg) + SUM_W'(len_reg) + SUM_W'(2);
    assign num_char = cur_byte inside {[CH_0:CH_9]};

    always_comb
    begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        len_next    = len_reg;
        rem_next    = rem_reg;
        res_valid   = 1'b0;
        res         = '{kind: KIND_DATA, payload_byte: 8'd0,
                        frame_bytes: '0, error_code: ERR_BADCHAR};
        case (phase_reg)
            PH_DATA:
            begin
                rem_next          = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_COMMA;
                end
                res_valid        = 1'b1;
                res.payload_byte = cur_byte;
            end
            PH_COMMA:
            begin
                phase_next  = PH_LEN;
                digits_next = 4'd0;
                len_next    = '0;
                rem_next    = '0;
                res_valid   = 1'b1;
                if (cur_byte == CH_COMMA)
                begin
                    res.kind        = KIND_DONE;
                    res.frame_bytes = total[FRAME_W-1:0];
                end
                else
                begin
                    res.kind       = KIND_ERR;
                    res.error_code = ERR_COMMA;
                end
            end
            default:
            begin
                // length phase, also the unused phase code
                phase_next = PH_LEN;
                if (num_char && digits_reg < MAX_DIG_C && len_x10[LEN_BITS+3:LEN_BITS] == 4'd0)
                begin
                    len_next    = len_x10[LEN_BITS-1:0];
                    digits_next = digits_reg + 4'd1;
                end
                else if (cur_byte == CH_COLON && digits_reg != 4'd0)
                begin
                    rem_next   = len_reg;
                    phase_next = (len_reg == '0) ? PH_COMMA : PH_DATA;
                end
                else
                begin
                    digits_next = 4'd0;
                    len_next    = '0;
                    rem_next    = '0;
                    res_valid   = 1'b1;
                    res.kind    = KIND_ERR;
                    if (num_char)
                    begin
                        res.error_code = ERR_OVERFLOW;
                    end
                    else if (cur_byte == CH_COLON)
                    begin
                        res.error_code = ERR_EMPTY;
                    end
                    else
                    begin
                        res.error_code = ERR_BADCHAR;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            digits_reg <= 4'd0;
            len_reg    <= '0;
            rem_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            len_reg    <= len_next;
            rem_reg    <= rem_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/netstr_out_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstr_out_stage
// result register driving the output channel
// ---------------------------------------------------------------------------
module netstr_out_stage
    import netstr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_t     res,
    output logic             slot_free,
    netstr_result_if.source  result_chan
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign slot_free = !valid_reg || result_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result_chan.valid        = valid_reg;
    assign result_chan.kind         = res_reg.kind;
    assign result_chan.payload_byte = res_reg.payload_byte;
    assign result_chan.frame_bytes  = res_reg.frame_bytes;
    assign result_chan.error_code   = res_reg.error_code;

endmodule
`default_nettype wire

FILE: hdl/netstring_deframer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstring_deframer
// netstring byte stream parser: passes payload bytes, reports frame length
// ---------------------------------------------------------------------------
// throughput: one byte per cycle while the result slot is free, set by
//   the single parse step per byte; a result becomes valid after its byte
//   passes the input register, then parse logic into the result register
// bytes that cause no result (length digits, colon) still take a parse step
// reset clears both stage valids and the parse state to the length phase
module netstring_deframer
    import netstr_pkg::*;
#(
    parameter int LEN_BITS   = 24,
    parameter int MAX_DIGITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    netstr_byte_if.sink      byte_chan,
    netstr_result_if.source  result_chan
);

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       slot_free;
    logic       advance;
    logic       res_valid;
    result_t    res;

    assign advance = s1_valid && slot_free;

    netstr_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_chan (byte_chan),
        .advance   (advance),
        .s1_valid  (s1_valid),
        .s1_byte   (s1_byte)
    );

    netstr_parse #(
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cur_byte  (s1_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    netstr_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && res_valid),
        .res         (res),
        .slot_free   (slot_free),
        .result_chan (result_chan)
    );

    // a byte taken while the input register is full must be replacing it
    a_in_replace: assert property (@(posedge clk) disable iff (!rst_n)
        byte_chan.valid && byte_chan.ready && s1_valid |-> advance)
        else $error("input register overwritten");

    // payload field only on data results
    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && result_chan.kind != KIND_DATA |-> result_chan.payload_byte == 8'd0)
        else $error("payload byte set on non-data result");

    // frame length only on completion results
    a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid && result_chan.kind != KIND_DONE |-> result_chan.frame_bytes == '0)
        else $error("frame length set on non-done result");

    // error code only on error results, and the unused kind never appears
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid |-> (result_chan.kind == KIND_ERR || result_chan.error_code == 2'd0)
                              && result_chan.kind != 2'd3)
        else $error("bad kind or stray error code");

endmodule
`default_nettype wire

FILE: tb/netstring_deframer_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// netstring_deframer_tb
// feeds directed and random netstring byte streams (good frames, syntax
// faults, overflow and junk) through the deframer with random gaps and stalls
// on both channels, and checks every result word against a byte-level parser
// ---------------------------------------------------------------------------
module netstring_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import netstr_pkg::*;

    localparam int LEN_BITS   = 24;
    localparam int MAX_DIGITS = 8;
    localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;

    logic clk = 1'b0;
    logic rst_n;

    netstr_byte_if   byte_chan ();
    netstr_result_if result_chan ();

    netstring_deframer #(
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan)
    );

    always #5 clk = ~clk;

    logic [7:0]          stream_bytes[$];
    result_t             expected_results[$];
    int unsigned         bytes_taken = 0;
    int unsigned         mismatches = 0;
    int unsigned         send_gap, send_calm = 0;
    int unsigned         recv_stall, recv_calm = 0;
    int unsigned         hold_left;
    bit                  hold_armed;

    // parser shadow state
    phase_t              parse_phase;
    logic [3:0]          digits_seen;
    logic [LEN_BITS-1:0] declared_len;
    logic [LEN_BITS-1:0] remaining_len;

    task automatic restart_parse();
        parse_phase   = PH_LEN;
        digits_seen   = '0;
        declared_len  = '0;
        remaining_len = '0;
    endtask

    // advance the shadow parser by one byte and queue the word it should produce
    task automatic parse_byte(input logic [7:0] b);
        result_t           r;
        logic [LEN_BITS+3:0] grown;
        bit                emit;
        r = '{kind: KIND_DATA, payload_byte: 8'd0, frame_bytes: '0, error_code: ERR_BADCHAR};
        emit = 1'b1;
        case (parse_phase)
            PH_DATA:
            begin
                remaining_len = remaining_len - 1'b1;
                if (remaining_len == 0)
                    parse_phase = PH_COMMA;
                r.payload_byte = b;
            end
            PH_COMMA:
            begin
                if (b == CH_COMMA)
                begin
                    r.kind = KIND_DONE;
                    r.frame_bytes = FRAME_W'(declared_len) + FRAME_W'(digits_seen) + FRAME_W'(2);
                end
                else
                begin
                    r.kind = KIND_ERR;
                    r.error_code = ERR_COMMA;
                end
                restart_parse();
            end
            default:
            begin
                if (b >= CH_0 && b <= CH_9)
                begin
                    grown = (LEN_BITS + 4)'(declared_len * 10 + (b - CH_0));
                    if (digits_seen >= MAX_DIGITS || grown[LEN_BITS+3:LEN_BITS] != '0)
                    begin
                        r.kind = KIND_ERR;
                        r.error_code = ERR_OVERFLOW;
                        restart_parse();
                    end
                    else
                    begin
                        declared_len = grown[LEN_BITS-1:0];
                        digits_seen = digits_seen + 4'd1;
                        parse_phase = PH_LEN;
                        emit = 1'b0;
                    end
                end
                else if (b == CH_COLON)
                begin
                    if (digits_seen == 0)
                    begin
                        r.kind = KIND_ERR;
                        r.error_code = ERR_EMPTY;
                        restart_parse();
                    end
                    else
                    begin
                        remaining_len = declared_len;
                        parse_phase = (declared_len == 0) ? PH_COMMA : PH_DATA;
                        emit = 1'b0;
                    end
                end
                else
                begin
                    r.kind = KIND_ERR;
                    r.error_code = ERR_BADCHAR;
                    restart_parse();
                end
            end
        endcase
        if (emit)
            expected_results.push_back(r);
    endtask

    // mostly no gap, some short, a few long, with occasional gap-free stretches
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        roll = $urandom_range(0, 999);
        if (calm != 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if (roll < 5)
        begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (roll < 500)
            return 0;
        if (roll < 850)
            return $urandom_range(1, 3);
        if (roll < 980)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // any byte that is neither a digit nor a colon
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b >= CH_0 && b <= CH_COLON);
        return b;
    endfunction

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(0, 8);
        if (roll < 98)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    task automatic push_text(input string s);
        foreach (s[i])
            stream_bytes.push_back(s[i]);
    endtask

    task automatic push_decimal(input int unsigned value, input int unsigned width);
        logic [7:0]  digs[$];
        int unsigned v;
        v = value;
        do
        begin
            digs.push_front(CH_0 + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        while (digs.size() < width)
            digs.push_front(CH_0);
        foreach (digs[i])
            stream_bytes.push_back(digs[i]);
    endtask

    // length with optional leading zeros, colon, random payload, closing byte
    task automatic push_frame(input int unsigned len, input logic [7:0] closer);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) stream_bytes.push_back(CH_0);
        push_decimal(len, 0);
        stream_bytes.push_back(CH_COLON);
        repeat (len) stream_bytes.push_back(8'($urandom_range(0, 255)));
        stream_bytes.push_back(closer);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_chan.valid   <= 1'b0;
            byte_chan.byte_in <= 8'd0;
            send_gap          <= 0;
        end
        else if (!byte_chan.valid || byte_chan.ready)
        begin
            if (send_gap != 0)
            begin
                byte_chan.valid <= 1'b0;
                send_gap        <= send_gap - 1;
            end
            else if (stream_bytes.size() != 0)
            begin
                byte_chan.valid   <= 1'b1;
                byte_chan.byte_in <= stream_bytes.pop_front();
                send_gap          <= pick_gap(send_calm);
            end
            else
                byte_chan.valid <= 1'b0;
        end
    end

    // one long receiver hold-off partway through, so the input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && bytes_taken >= 400)
        begin
            hold_left  <= 200;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor: predicts on accepted bytes, then checks accepted result words
    always @(posedge clk or negedge rst_n)
    begin : result_watch
        result_t want;
        if (!rst_n)
        begin
            result_chan.ready <= 1'b0;
            recv_stall        <= 0;
            restart_parse();
        end
        else
        begin
            if (byte_chan.valid && byte_chan.ready)
            begin
                parse_byte(byte_chan.byte_in);
                bytes_taken <= bytes_taken + 1;
            end
            if (result_chan.valid && result_chan.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got kind %0d byte %0h frame %0d err %0d",
                             $time, result_chan.kind, result_chan.payload_byte,
                             result_chan.frame_bytes, result_chan.error_code);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_chan.kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d got %0d", $time, want.kind, result_chan.kind);
                        mismatches++;
                    end
                    if (result_chan.payload_byte !== want.payload_byte)
                    begin
                        $display("%0t: payload_byte expected %0h got %0h",
                                 $time, want.payload_byte, result_chan.payload_byte);
                        mismatches++;
                    end
                    if (result_chan.frame_bytes !== want.frame_bytes)
                    begin
                        $display("%0t: frame_bytes expected %0d got %0d",
                                 $time, want.frame_bytes, result_chan.frame_bytes);
                        mismatches++;
                    end
                    if (result_chan.error_code !== want.error_code)
                    begin
                        $display("%0t: error_code expected %0d got %0d",
                                 $time, want.error_code, result_chan.error_code);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
                result_chan.ready <= 1'b0;
            else if (recv_stall != 0)
            begin
                result_chan.ready <= 1'b0;
                recv_stall        <= recv_stall - 1;
            end
            else
            begin
                result_chan.ready <= 1'b1;
                recv_stall        <= pick_gap(recv_calm);
            end
        end
    end

    initial
    begin
        int unsigned random_start;
        int unsigned roll;
        logic [7:0]  b;

        rst_n = 1'b0;

        // directed: zero length, leading zero with extreme payload bytes,
        // bad char, empty length, wrong closer, too many digits, length too big
        push_text("0:,");
        push_text("02:");
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h00);
        push_text(",");
        stream_bytes.push_back(8'h00);
        push_text(":");
        push_text("1:AB");
        push_text("000000000");
        push_text("20000000");

        random_start = stream_bytes.size();
        push_frame(300, CH_COMMA);
        while (stream_bytes.size() - random_start < 1200)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                push_frame(pick_length(), CH_COMMA);
            else if (roll < 76)
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_COMMA);
                push_frame(pick_length(), b);
            end
            else if (roll < 80)
            begin
                repeat ($urandom_range(0, 3)) stream_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
                stream_bytes.push_back(pick_junk());
            end
            else if (roll < 83)
                stream_bytes.push_back(CH_COLON);
            else if (roll < 88)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_decimal($urandom_range(0, LEN_MAX), MAX_DIGITS);
                    stream_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
                end
                else
                    push_decimal($urandom_range(LEN_MAX + 1, 99999999), MAX_DIGITS);
            end
            else
            begin
                // junk without colons stays in the length phase; a non-digit resyncs
                repeat ($urandom_range(1, 6))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_COLON);
                    stream_bytes.push_back(b);
                end
                stream_bytes.push_back(pick_junk());
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (stream_bytes.size() != 0 || byte_chan.valid)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
